>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the interpolation core.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qslp_pkg.sv
// Package for the quaternion interpolation core: widths, pipeline stage map,
// side-band record, arctangent and gain tables, saturation helper.
// No dependencies.
package qslp_pkg;

  localparam int ITERATIONS = 16;
  localparam int N_STEPS = (ITERATIONS < 8) ? 8 : ((ITERATIONS > 24) ? 24 : ITERATIONS);

  localparam int IDX_W    = 5;
  localparam int SQ_W     = 61;
  localparam int SQ_STEPS = 31;
  localparam int XY_W     = 36;
  localparam int Z_W      = 34;
  localparam int DEN_W    = 31;
  localparam int DR_W     = 32;
  localparam int DQ_W     = 43;
  localparam int W_W      = 44;
  localparam int P_W      = 61;
  localparam int T_ONE    = 32768;

  localparam logic [DEN_W-1:0] SIN_FLOOR = 31'd1073742;

  // pipeline stage map
  localparam int ST_IN    = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_DOT   = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_SQRT0 = 4;
  localparam int ST_VEC0  = ST_SQRT0 + SQ_STEPS;
  localparam int ST_MUL   = ST_VEC0 + N_STEPS;
  localparam int ST_ROT0  = ST_MUL + 1;
  localparam int ST_DIV0  = ST_ROT0 + N_STEPS;
  localparam int ST_WMUL  = ST_DIV0 + DQ_W;
  localparam int ST_OUT   = ST_WMUL + 1;
  localparam int LAT      = ST_OUT + 1;

  typedef enum logic [1:0] {
    MODE_SLERP,
    MODE_START,
    MODE_MID
  } mode_t;

  typedef struct packed {
    logic [3:0][15:0] s;
    logic [3:0][16:0] e;
    logic [15:0]      t;
    mode_t            mode;
    logic [29:0]      c;
    logic [DEN_W-1:0] sn;
    logic             na;
    logic             nb;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      default: a = Z_W'(34'sd1 << (30 - i));
    endcase
    return a;
  endfunction

  function automatic logic signed [XY_W-1:0] gain_q30(input int n);
    logic signed [XY_W-1:0] g;
    case (n)
      8:       g = 36'sd652039507;
      9:       g = 36'sd652034532;
      10:      g = 36'sd652033289;
      11:      g = 36'sd652032978;
      12:      g = 36'sd652032900;
      13:      g = 36'sd652032881;
      14:      g = 36'sd652032876;
      default: g = 36'sd652032874;
    endcase
    return g;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'h7fff;
    end else if (v < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/qslp_sqrt_cell.sv
// One bit step of the pipelined integer square root.
// Depends on qslp_pkg.
module qslp_sqrt_cell import qslp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] k,
  input  logic [SQ_W-1:0]  rem_in,
  input  logic [SQ_W-1:0]  root_in,
  output logic [SQ_W-1:0]  rem_r,
  output logic [SQ_W-1:0]  root_r
);
  logic [SQ_W:0]   bitv;
  logic [SQ_W:0]   trial;
  logic            ge;
  logic [SQ_W-1:0] rem_nxt;
  logic [SQ_W-1:0] root_nxt;

  always_comb begin
    bitv     = (SQ_W+1)'(1) << {k, 1'b0};
    trial    = {1'b0, root_in} + bitv;
    ge       = ({1'b0, rem_in} >= trial);
    rem_nxt  = ge ? SQ_W'({1'b0, rem_in} - trial) : rem_in;
    root_nxt = ge ? SQ_W'({2'b0, root_in[SQ_W-1:1]} + bitv) : {1'b0, root_in[SQ_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end
endmodule

>>> rtl/core/qslp_cordic_cell.sv
// One micro-rotation of a CORDIC, vectoring or rotation mode.
// Depends on qslp_pkg.
module qslp_cordic_cell import qslp_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   vec,
  input  logic [IDX_W-1:0]       idx,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  output logic signed [XY_W-1:0] x_r,
  output logic signed [XY_W-1:0] y_r,
  output logic signed [Z_W-1:0]  z_r
);
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  a;
  logic                   sub_x;
  logic signed [XY_W-1:0] x_nxt;
  logic signed [XY_W-1:0] y_nxt;
  logic signed [Z_W-1:0]  z_nxt;

  always_comb begin
    xs    = x_in >>> idx;
    ys    = y_in >>> idx;
    a     = atan_q30(idx);
    // vectoring drives y to zero, rotation drives z to zero
    sub_x = vec ? !(y_in > 0) : (z_in >= 0);
    x_nxt = sub_x ? x_in - ys : x_in + ys;
    y_nxt = sub_x ? y_in + xs : y_in - xs;
    z_nxt = sub_x ? z_in - a : z_in + a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

>>> rtl/core/qslp_div_cell.sv
// One restoring step of the pipelined unsigned divider.
// Depends on qslp_pkg.
module qslp_div_cell import qslp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic [DR_W-1:0]  rem_in,
  input  logic [DQ_W-1:0]  low_in,
  output logic [DR_W-1:0]  rem_r,
  output logic [DQ_W-1:0]  low_r
);
  logic [DR_W-1:0] rs;
  logic            ge;
  logic [DR_W-1:0] rem_nxt;
  logic [DQ_W-1:0] low_nxt;

  always_comb begin
    // shift in the next dividend bit, shift one quotient bit into the low word
    rs      = {rem_in[DR_W-2:0], low_in[DQ_W-1]};
    ge      = (rs >= DR_W'(den));
    rem_nxt = ge ? rs - DR_W'(den) : rs;
    low_nxt = {low_in[DQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end
endmodule

>>> rtl/core/quaternion_slerp_top.sv
// Top level of the quaternion interpolation core: glue stages and cell rows.
// Depends on qslp_pkg, the three cell modules and assert_macros.svh.
//
// Usage:
// - Input channel in_*: start and end quaternions (Q2.14) and fraction t
//   (Q1.15, values above one count as one). A transaction is taken at a rising
//   edge with in_valid high and in_stall low.
// - Output channel out_*: the interpolated quaternion, Q2.14, saturated.
// - Each transaction runs down one pipeline of 81 + 2*N_STEPS register stages
//   (113 at 16 CORDIC steps): dot product, a 31-cell square root row, an
//   N_STEPS cell vectoring CORDIC, two N_STEPS rotation rows side by side, two
//   43-cell divider rows and the blend/round stage. out_valid rises once the
//   transaction reaches the output register, from which the result is taken.
// - Throughput is one transaction per cycle while in_stall is low; every stage
//   is a register stage, so a new item may enter each cycle that in_stall is low.
// - When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises; bubbles ahead of the output still let the input in
//   while the output register is empty.
// - Reset (rst_n low, synchronous) clears all valid bits; payload registers
//   are not reset. No clearing pass is needed.
`include "assert_macros.svh"
module quaternion_slerp_top import qslp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_start_w,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_start_z,
  input  logic [15:0] in_end_w,
  input  logic [15:0] in_end_x,
  input  logic [15:0] in_end_y,
  input  logic [15:0] in_end_z,
  input  logic [15:0] in_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_w,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_z
);

  logic              en;
  logic [LAT-1:0]    v_r;
  logic [LAT-1:0]    v_nxt;
  side_t             side_r   [LAT];
  side_t             side_nxt [LAT];

  logic signed [31:0] prod_r [4];
  logic signed [31:0] prod_nxt [4];
  logic [59:0]        csq_r;
  logic [59:0]        csq_nxt;
  logic signed [Z_W-1:0] ta_r, tb_r, ta_nxt, tb_nxt;
  logic signed [P_W-1:0] pa_r [4];
  logic signed [P_W-1:0] pb_r [4];
  logic signed [P_W-1:0] pa_nxt [4];
  logic signed [P_W-1:0] pb_nxt [4];
  logic [3:0][15:0]   out_r;
  logic [3:0][15:0]   out_nxt;

  // stage-to-stage links of the cell rows
  logic [SQ_W-1:0]        sq_rem  [SQ_STEPS+1];
  logic [SQ_W-1:0]        sq_root [SQ_STEPS+1];
  logic signed [XY_W-1:0] vx [N_STEPS+1];
  logic signed [XY_W-1:0] vy [N_STEPS+1];
  logic signed [Z_W-1:0]  vz [N_STEPS+1];
  logic signed [XY_W-1:0] rax [N_STEPS+1];
  logic signed [XY_W-1:0] ray [N_STEPS+1];
  logic signed [Z_W-1:0]  raz [N_STEPS+1];
  logic signed [XY_W-1:0] rbx [N_STEPS+1];
  logic signed [XY_W-1:0] rby [N_STEPS+1];
  logic signed [Z_W-1:0]  rbz [N_STEPS+1];
  logic [DR_W-1:0]        dra [DQ_W+1];
  logic [DQ_W-1:0]        dla [DQ_W+1];
  logic [DR_W-1:0]        drb [DQ_W+1];
  logic [DQ_W-1:0]        dlb [DQ_W+1];

  // advance whenever the output register is free or being taken
  assign en       = !v_r[ST_OUT] || !out_stall;
  assign in_stall = !en;

  always_comb begin
    v_nxt = {v_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // side-band record: copied stage to stage, updated at a few stages
  always_comb begin
    logic signed [33:0] dot;
    logic [33:0]        dabs;
    logic               neg;
    logic [16:0]        tcl;
    logic signed [XY_W-1:0] ya;
    logic signed [XY_W-1:0] yb;

    side_nxt[ST_IN] = '0;
    side_nxt[ST_IN].s    = {in_start_z, in_start_y, in_start_x, in_start_w};
    side_nxt[ST_IN].e[0] = {in_end_w[15], in_end_w};
    side_nxt[ST_IN].e[1] = {in_end_x[15], in_end_x};
    side_nxt[ST_IN].e[2] = {in_end_y[15], in_end_y};
    side_nxt[ST_IN].e[3] = {in_end_z[15], in_end_z};
    tcl = (in_fraction > 16'(T_ONE)) ? 17'(T_ONE) : {1'b0, in_fraction};
    side_nxt[ST_IN].t    = tcl[15:0];
    side_nxt[ST_IN].mode = MODE_SLERP;

    for (int k = 1; k < LAT; k++) begin
      side_nxt[k] = side_r[k-1];
    end

    // sign of the dot product, flip end, detect cosine at one
    dot = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]) + 34'(prod_r[3]);
    neg = dot[33];
    dabs = neg ? -dot : dot;
    if (neg) begin
      for (int k = 0; k < 4; k++) begin
        side_nxt[ST_DOT].e[k] = -side_r[ST_DOT-1].e[k];
      end
    end
    side_nxt[ST_DOT].c    = {dabs[27:0], 2'b00};
    side_nxt[ST_DOT].mode = (dabs >= 34'(1 << 28)) ? MODE_START : MODE_SLERP;

    // sine from the root row, small sine takes the midpoint
    side_nxt[ST_VEC0].sn = sq_root[SQ_STEPS][DEN_W-1:0];
    if (side_r[ST_VEC0-1].mode == MODE_SLERP &&
        sq_root[SQ_STEPS][DEN_W-1:0] < SIN_FLOOR) begin
      side_nxt[ST_VEC0].mode = MODE_MID;
    end

    // signs of the two weight numerators
    ya = ray[N_STEPS];
    yb = rby[N_STEPS];
    side_nxt[ST_DIV0].na = ya[XY_W-1];
    side_nxt[ST_DIV0].nb = yb[XY_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LAT; k++) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // products of the dot, square of the cosine
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = $signed(side_r[ST_IN].s[k]) * $signed(side_r[ST_IN].e[k][15:0]);
    end
    csq_nxt = 60'(side_r[ST_DOT].c) * 60'(side_r[ST_DOT].c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      csq_r  <= csq_nxt;
    end
  end

  // square root row: sin = floor(sqrt(2^60 - cos^2))
  assign sq_rem[0]  = SQ_W'(61'd1 << 60) - SQ_W'(csq_r);
  assign sq_root[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    qslp_sqrt_cell u_cell (
      .clk     (clk),
      .en      (en),
      .k       (IDX_W'(SQ_STEPS - 1 - j)),
      .rem_in  (sq_rem[j]),
      .root_in (sq_root[j]),
      .rem_r   (sq_rem[j+1]),
      .root_r  (sq_root[j+1])
    );
  end

  // vectoring row: half angle from (cos, sin)
  assign vx[0] = XY_W'(side_r[ST_VEC0-1].c);
  assign vy[0] = XY_W'(sq_root[SQ_STEPS][DEN_W-1:0]);
  assign vz[0] = '0;

  for (genvar i = 0; i < N_STEPS; i++) begin : g_vec
    qslp_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .vec  (1'b1),
      .idx  (IDX_W'(i)),
      .x_in (vx[i]),
      .y_in (vy[i]),
      .z_in (vz[i]),
      .x_r  (vx[i+1]),
      .y_r  (vy[i+1]),
      .z_r  (vz[i+1])
    );
  end

  // scale the angle by 1-t and by t
  always_comb begin
    logic signed [17:0] fa;
    logic signed [17:0] fb;
    logic signed [51:0] ma;
    logic signed [51:0] mb;
    fa = 18'(T_ONE) - 18'(side_r[ST_MUL-1].t);
    fb = 18'(side_r[ST_MUL-1].t);
    ma = vz[N_STEPS] * fa;
    mb = vz[N_STEPS] * fb;
    ta_nxt = ma[Z_W+14:15];
    tb_nxt = mb[Z_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
    end
  end

  // two rotation rows for the two sines
  assign rax[0] = gain_q30(N_STEPS);
  assign ray[0] = '0;
  assign raz[0] = ta_r;
  assign rbx[0] = gain_q30(N_STEPS);
  assign rby[0] = '0;
  assign rbz[0] = tb_r;

  for (genvar i = 0; i < N_STEPS; i++) begin : g_rot
    qslp_cordic_cell u_cell_a (
      .clk  (clk),
      .en   (en),
      .vec  (1'b0),
      .idx  (IDX_W'(i)),
      .x_in (rax[i]),
      .y_in (ray[i]),
      .z_in (raz[i]),
      .x_r  (rax[i+1]),
      .y_r  (ray[i+1]),
      .z_r  (raz[i+1])
    );
    qslp_cordic_cell u_cell_b (
      .clk  (clk),
      .en   (en),
      .vec  (1'b0),
      .idx  (IDX_W'(i)),
      .x_in (rbx[i]),
      .y_in (rby[i]),
      .z_in (rbz[i]),
      .x_r  (rbx[i+1]),
      .y_r  (rby[i+1]),
      .z_r  (rbz[i+1])
    );
  end

  // divider rows: |sine| clamped to 2^32, shifted by 30, over sin
  always_comb begin
    logic signed [XY_W-1:0] ya;
    logic signed [XY_W-1:0] yb;
    logic [XY_W-1:0]        mga;
    logic [XY_W-1:0]        mgb;
    logic [32:0]            ma;
    logic [32:0]            mb;
    ya  = ray[N_STEPS];
    yb  = rby[N_STEPS];
    mga = ya[XY_W-1] ? XY_W'(-ya) : XY_W'(ya);
    mgb = yb[XY_W-1] ? XY_W'(-yb) : XY_W'(yb);
    ma  = (mga > XY_W'(36'd1 << 32)) ? 33'd1 << 32 : mga[32:0];
    mb  = (mgb > XY_W'(36'd1 << 32)) ? 33'd1 << 32 : mgb[32:0];
    dra[0] = DR_W'(ma[32:13]);
    dla[0] = {ma[12:0], 30'd0};
    drb[0] = DR_W'(mb[32:13]);
    dlb[0] = {mb[12:0], 30'd0};
  end

  for (genvar j = 0; j < DQ_W; j++) begin : g_div
    qslp_div_cell u_cell_a (
      .clk    (clk),
      .en     (en),
      .den    (side_r[ST_DIV0+j-1].sn),
      .rem_in (dra[j]),
      .low_in (dla[j]),
      .rem_r  (dra[j+1]),
      .low_r  (dla[j+1])
    );
    qslp_div_cell u_cell_b (
      .clk    (clk),
      .en     (en),
      .den    (side_r[ST_DIV0+j-1].sn),
      .rem_in (drb[j]),
      .low_in (dlb[j]),
      .rem_r  (drb[j+1]),
      .low_r  (dlb[j+1])
    );
  end

  // weighted components
  always_comb begin
    logic signed [W_W-1:0] wa;
    logic signed [W_W-1:0] wb;
    wa = side_r[ST_WMUL-1].na ? -W_W'(dla[DQ_W]) : W_W'(dla[DQ_W]);
    wb = side_r[ST_WMUL-1].nb ? -W_W'(dlb[DQ_W]) : W_W'(dlb[DQ_W]);
    for (int k = 0; k < 4; k++) begin
      pa_nxt[k] = P_W'($signed(side_r[ST_WMUL-1].s[k]) * wa);
      pb_nxt[k] = P_W'($signed(side_r[ST_WMUL-1].e[k]) * wb);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // round half up, saturate, pick by case
  always_comb begin
    logic signed [P_W:0]  acc;
    logic signed [P_W:0]  rnd;
    logic signed [17:0]   mid;
    for (int k = 0; k < 4; k++) begin
      acc = (P_W+1)'(pa_r[k]) + (P_W+1)'(pb_r[k]) + (P_W+1)'(1 << 29);
      rnd = acc >>> 30;
      mid = (18'($signed(side_r[ST_WMUL].s[k])) + 18'($signed(side_r[ST_WMUL].e[k]))) >>> 1;
      case (side_r[ST_WMUL].mode)
        MODE_START: out_nxt[k] = side_r[ST_WMUL].s[k];
        MODE_MID:   out_nxt[k] = sat16(32'(mid));
        default:    out_nxt[k] = sat16(rnd[31:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[ST_OUT];
  assign out_w     = out_r[0];
  assign out_x     = out_r[1];
  assign out_y     = out_r[2];
  assign out_z     = out_r[3];

  // accepted transaction lands in the first stage
  `ASSERT_CLK(a_accept_enters, (in_valid && !in_stall) |=> v_r[ST_IN], "accepted transaction lost at entry")
  // the pipeline freezes while the output is stalled
  `ASSERT_CLK(a_freeze, (out_valid && out_stall) |=> $stable(v_r), "pipeline moved during stall")
  // a new result comes from the stage before the output
  `ASSERT_CLK(a_out_source, $rose(out_valid) |-> $past(v_r[ST_WMUL]), "result without a source")

endmodule
